// ===== hdl/mimu_pkg.sv =====
// shared types, widths and the product sequence of the orientation update unit
package mimu_pkg;

    localparam int DW  = 32;
    localparam int MW  = 33;
    localparam int PW  = 2 * MW;
    localparam int NW  = 49;
    localparam int QW  = 32;
    localparam int AW  = 64;
    localparam int PCW = 6;

    localparam logic [PCW-1:0] PC_GYRO_END = PCW'(11);
    localparam logic [PCW-1:0] PC_END      = PCW'(39);

    localparam logic REG_GAIN = 1'b0;
    localparam logic REG_STEP = 1'b1;

    localparam logic [DW-1:0] GAIN_RST = DW'(6554);
    localparam logic [DW-1:0] STEP_RST = DW'(143165577);
    localparam logic signed [QW-1:0] Q30_ONE = QW'(1) <<< 30;

    typedef logic signed [MW-1:0] mopnd_t;
    typedef logic signed [PW-1:0] mprod_t;
    typedef logic signed [NW-1:0] nvec_t;
    typedef logic signed [QW-1:0] nres_t;

    typedef struct packed {
        mopnd_t a;
        mopnd_t b;
    } mul_req_t;

    typedef struct packed {
        logic start;
        logic four;
    } norm_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } norm_sts_t;

    typedef enum logic [3:0] {
        OP_Q0, OP_Q1, OP_Q2, OP_Q3,
        OP_GX, OP_GY, OP_GZ,
        OP_AX, OP_AY, OP_AZ,
        OP_QQ0, OP_QQ1, OP_QQ2, OP_QQ3,
        OP_ONE
    } opnd_t;

    typedef enum logic [1:0] {
        DST_QD, DST_QQ, DST_S
    } dst_t;

    typedef struct packed {
        opnd_t      a;
        opnd_t      b;
        logic       raw;
        logic       neg;
        logic [1:0] shl;
        logic       last;
        dst_t       dst;
        logic [1:0] idx;
    } prog_t;

    function automatic prog_t mk(input opnd_t a, input opnd_t b, input logic raw,
                                 input logic neg, input logic [1:0] shl, input logic last,
                                 input dst_t dst, input logic [1:0] idx);
        prog_t e;
        e.a    = a;
        e.b    = b;
        e.raw  = raw;
        e.neg  = neg;
        e.shl  = shl;
        e.last = last;
        e.dst  = dst;
        e.idx  = idx;
        return e;
    endfunction

    // rate products, quaternion squares, then the gradient terms
    function automatic prog_t prog_entry(input logic [PCW-1:0] pc);
        prog_t e;
        case (pc)
            6'd0:  e = mk(OP_Q1,  OP_GX,  1'b1, 1'b1, 2'd0, 1'b0, DST_QD, 2'd0);
            6'd1:  e = mk(OP_Q2,  OP_GY,  1'b1, 1'b1, 2'd0, 1'b0, DST_QD, 2'd0);
            6'd2:  e = mk(OP_Q3,  OP_GZ,  1'b1, 1'b1, 2'd0, 1'b1, DST_QD, 2'd0);
            6'd3:  e = mk(OP_Q0,  OP_GX,  1'b1, 1'b0, 2'd0, 1'b0, DST_QD, 2'd1);
            6'd4:  e = mk(OP_Q2,  OP_GZ,  1'b1, 1'b0, 2'd0, 1'b0, DST_QD, 2'd1);
            6'd5:  e = mk(OP_Q3,  OP_GY,  1'b1, 1'b1, 2'd0, 1'b1, DST_QD, 2'd1);
            6'd6:  e = mk(OP_Q0,  OP_GY,  1'b1, 1'b0, 2'd0, 1'b0, DST_QD, 2'd2);
            6'd7:  e = mk(OP_Q1,  OP_GZ,  1'b1, 1'b1, 2'd0, 1'b0, DST_QD, 2'd2);
            6'd8:  e = mk(OP_Q3,  OP_GX,  1'b1, 1'b0, 2'd0, 1'b1, DST_QD, 2'd2);
            6'd9:  e = mk(OP_Q0,  OP_GZ,  1'b1, 1'b0, 2'd0, 1'b0, DST_QD, 2'd3);
            6'd10: e = mk(OP_Q1,  OP_GY,  1'b1, 1'b0, 2'd0, 1'b0, DST_QD, 2'd3);
            6'd11: e = mk(OP_Q2,  OP_GX,  1'b1, 1'b1, 2'd0, 1'b1, DST_QD, 2'd3);
            6'd12: e = mk(OP_Q0,  OP_Q0,  1'b0, 1'b0, 2'd0, 1'b1, DST_QQ, 2'd0);
            6'd13: e = mk(OP_Q1,  OP_Q1,  1'b0, 1'b0, 2'd0, 1'b1, DST_QQ, 2'd1);
            6'd14: e = mk(OP_Q2,  OP_Q2,  1'b0, 1'b0, 2'd0, 1'b1, DST_QQ, 2'd2);
            6'd15: e = mk(OP_Q3,  OP_Q3,  1'b0, 1'b0, 2'd0, 1'b1, DST_QQ, 2'd3);
            6'd16: e = mk(OP_Q0,  OP_QQ2, 1'b0, 1'b0, 2'd2, 1'b0, DST_S,  2'd0);
            6'd17: e = mk(OP_Q2,  OP_AX,  1'b0, 1'b0, 2'd1, 1'b0, DST_S,  2'd0);
            6'd18: e = mk(OP_Q0,  OP_QQ1, 1'b0, 1'b0, 2'd2, 1'b0, DST_S,  2'd0);
            6'd19: e = mk(OP_Q1,  OP_AY,  1'b0, 1'b1, 2'd1, 1'b1, DST_S,  2'd0);
            6'd20: e = mk(OP_Q1,  OP_QQ3, 1'b0, 1'b0, 2'd2, 1'b0, DST_S,  2'd1);
            6'd21: e = mk(OP_Q3,  OP_AX,  1'b0, 1'b1, 2'd1, 1'b0, DST_S,  2'd1);
            6'd22: e = mk(OP_QQ0, OP_Q1,  1'b0, 1'b0, 2'd2, 1'b0, DST_S,  2'd1);
            6'd23: e = mk(OP_Q0,  OP_AY,  1'b0, 1'b1, 2'd1, 1'b0, DST_S,  2'd1);
            6'd24: e = mk(OP_Q1,  OP_ONE, 1'b0, 1'b1, 2'd2, 1'b0, DST_S,  2'd1);
            6'd25: e = mk(OP_Q1,  OP_QQ1, 1'b0, 1'b0, 2'd3, 1'b0, DST_S,  2'd1);
            6'd26: e = mk(OP_Q1,  OP_QQ2, 1'b0, 1'b0, 2'd3, 1'b0, DST_S,  2'd1);
            6'd27: e = mk(OP_Q1,  OP_AZ,  1'b0, 1'b0, 2'd2, 1'b1, DST_S,  2'd1);
            6'd28: e = mk(OP_QQ0, OP_Q2,  1'b0, 1'b0, 2'd2, 1'b0, DST_S,  2'd2);
            6'd29: e = mk(OP_Q0,  OP_AX,  1'b0, 1'b0, 2'd1, 1'b0, DST_S,  2'd2);
            6'd30: e = mk(OP_Q2,  OP_QQ3, 1'b0, 1'b0, 2'd2, 1'b0, DST_S,  2'd2);
            6'd31: e = mk(OP_Q3,  OP_AY,  1'b0, 1'b1, 2'd1, 1'b0, DST_S,  2'd2);
            6'd32: e = mk(OP_Q2,  OP_ONE, 1'b0, 1'b1, 2'd2, 1'b0, DST_S,  2'd2);
            6'd33: e = mk(OP_Q2,  OP_QQ1, 1'b0, 1'b0, 2'd3, 1'b0, DST_S,  2'd2);
            6'd34: e = mk(OP_Q2,  OP_QQ2, 1'b0, 1'b0, 2'd3, 1'b0, DST_S,  2'd2);
            6'd35: e = mk(OP_Q2,  OP_AZ,  1'b0, 1'b0, 2'd2, 1'b1, DST_S,  2'd2);
            6'd36: e = mk(OP_QQ1, OP_Q3,  1'b0, 1'b0, 2'd2, 1'b0, DST_S,  2'd3);
            6'd37: e = mk(OP_Q1,  OP_AX,  1'b0, 1'b1, 2'd1, 1'b0, DST_S,  2'd3);
            6'd38: e = mk(OP_QQ2, OP_Q3,  1'b0, 1'b0, 2'd2, 1'b0, DST_S,  2'd3);
            6'd39: e = mk(OP_Q2,  OP_AY,  1'b0, 1'b1, 2'd1, 1'b1, DST_S,  2'd3);
            default: e = mk(OP_ONE, OP_ONE, 1'b0, 1'b0, 2'd0, 1'b0, DST_S, 2'd0);
        endcase
        return e;
    endfunction

endpackage

// ===== hdl/mimu_mul.sv =====
// shared signed multiplier with registered product
module mimu_mul (
    input  logic               aclk,
    input  mimu_pkg::mul_req_t req,
    output mimu_pkg::mprod_t   prod
);
    import mimu_pkg::*;

    mprod_t prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= req.a * req.b;
    end

    assign prod = prod_reg;

endmodule

// ===== hdl/mimu_norm.sv =====
// iterative vector normaliser: scaling shift, sum of squares, integer root, division
module mimu_norm (
    input  logic                aclk,
    input  logic                aresetn,
    input  mimu_pkg::norm_ctl_t ctl,
    input  mimu_pkg::nvec_t     vec [4],
    output mimu_pkg::norm_sts_t sts,
    output mimu_pkg::nres_t     res [4],
    output mimu_pkg::mul_req_t  req,
    input  mimu_pkg::mprod_t    prod
);
    import mimu_pkg::*;

    typedef enum logic [2:0] {
        N_IDLE, N_MAX, N_SHIFT, N_SQ, N_ALIGN, N_SQRT, N_DIV
    } nstate_t;

    localparam logic [4:0] DIV_TOP = 5'd30;

    nstate_t        state_reg;
    logic [NW-1:0]  mg_reg [4];
    logic [3:0]     neg_reg;
    logic [NW-1:0]  m_reg;
    logic           four_reg;
    logic [AW-1:0]  sum_reg;
    logic [AW-1:0]  x_reg;
    logic [AW-1:0]  r_reg;
    logic [AW-1:0]  bit_reg;
    logic [31:0]    rem_reg;
    logic [30:0]    qt_reg;
    logic [4:0]     cnt_reg;
    logic [1:0]     k_reg;
    logic           ph_reg;
    logic           done_reg;
    nres_t          res_reg [4];

    logic [NW-1:0]  mx01, mx23, mx;
    logic [AW-1:0]  rb;
    logic [32:0]    rem2;
    logic           ge;
    logic [31:0]    rem_next;
    logic [30:0]    qt_next;
    logic [1:0]     kn;
    logic [NW-1:0]  mgk;
    logic           done_next;

    always_comb begin
        mx01     = (mg_reg[0] > mg_reg[1]) ? mg_reg[0] : mg_reg[1];
        mx23     = (mg_reg[2] > mg_reg[3]) ? mg_reg[2] : mg_reg[3];
        mx       = (mx01 > mx23) ? mx01 : mx23;
        rb       = r_reg + bit_reg;
        mgk      = mg_reg[k_reg];
        rem2     = {rem_reg, (cnt_reg == DIV_TOP) ? mgk[0] : 1'b0};
        ge       = rem2 >= {1'b0, r_reg[31:0]};
        rem_next = ge ? 32'(rem2 - {1'b0, r_reg[31:0]}) : rem2[31:0];
        qt_next  = {qt_reg[29:0], ge};
        kn       = k_reg + 2'd1;
        req.a    = mopnd_t'({2'b00, mgk[30:0]});
        req.b    = mopnd_t'({2'b00, mgk[30:0]});
        done_next = ((state_reg == N_MAX) && (mx == '0))
                 || ((state_reg == N_DIV) && (cnt_reg == '0)
                     && (k_reg == (four_reg ? 2'd3 : 2'd2)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= done_next;
            case (state_reg)
                N_IDLE: begin
                    if (ctl.start) begin
                        for (int i = 0; i < 4; i++) begin
                            nvec_t v;
                            v = (i == 3 && !ctl.four) ? '0 : vec[i];
                            mg_reg[i]  <= v[NW-1] ? NW'(-v) : NW'(v);
                            neg_reg[i] <= v[NW-1];
                            res_reg[i] <= '0;
                        end
                        four_reg  <= ctl.four;
                        state_reg <= N_MAX;
                    end
                end
                N_MAX: begin
                    if (mx == '0) begin
                        state_reg <= N_IDLE;
                    end else begin
                        m_reg     <= mx;
                        state_reg <= N_SHIFT;
                    end
                end
                N_SHIFT: begin
                    if (m_reg[NW-1:31] != '0) begin
                        for (int i = 0; i < 4; i++) mg_reg[i] <= mg_reg[i] >> 1;
                        m_reg <= m_reg >> 1;
                    end else if (!m_reg[30]) begin
                        for (int i = 0; i < 4; i++) mg_reg[i] <= mg_reg[i] << 1;
                        m_reg <= m_reg << 1;
                    end else begin
                        sum_reg   <= '0;
                        k_reg     <= 2'd0;
                        ph_reg    <= 1'b0;
                        state_reg <= N_SQ;
                    end
                end
                N_SQ: begin
                    ph_reg <= !ph_reg;
                    if (ph_reg) begin
                        sum_reg <= sum_reg + prod[AW-1:0];
                        k_reg   <= kn;
                        if (k_reg == 2'd3) begin
                            x_reg     <= sum_reg + prod[AW-1:0];
                            r_reg     <= '0;
                            bit_reg   <= AW'(1) << 62;
                            state_reg <= N_ALIGN;
                        end
                    end
                end
                N_ALIGN: begin
                    if (bit_reg > x_reg) bit_reg <= bit_reg >> 2;
                    else state_reg <= N_SQRT;
                end
                N_SQRT: begin
                    if (bit_reg == '0) begin
                        k_reg     <= 2'd0;
                        rem_reg   <= {2'b00, mg_reg[0][30:1]};
                        qt_reg    <= '0;
                        cnt_reg   <= DIV_TOP;
                        state_reg <= N_DIV;
                    end else begin
                        if (x_reg >= rb) begin
                            x_reg <= x_reg - rb;
                            r_reg <= (r_reg >> 1) + bit_reg;
                        end else begin
                            r_reg <= r_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                end
                N_DIV: begin
                    if (cnt_reg != '0) begin
                        rem_reg <= rem_next;
                        qt_reg  <= qt_next;
                        cnt_reg <= cnt_reg - 5'd1;
                    end else begin
                        res_reg[k_reg] <= neg_reg[k_reg] ? -nres_t'({1'b0, qt_next})
                                                         : nres_t'({1'b0, qt_next});
                        if (k_reg == (four_reg ? 2'd3 : 2'd2)) begin
                            state_reg <= N_IDLE;
                        end else begin
                            k_reg   <= kn;
                            rem_reg <= {2'b00, mg_reg[kn][30:1]};
                            qt_reg  <= '0;
                            cnt_reg <= DIV_TOP;
                        end
                    end
                end
                default: state_reg <= N_IDLE;
            endcase
        end
    end

    assign sts.busy = (state_reg != N_IDLE);
    assign sts.done = done_reg;
    assign res = res_reg;

endmodule

// ===== hdl/madgwick_imu_orientation_update_unit.sv =====
// top level of the imu orientation update unit: sequencer, state and stream ports
// sequence: the rate products, then with a nonzero accelerometer sample the gradient products
// and gain steps, then the integration steps; plus the normalisations (an all-zero vector
// ends early), three with a nonzero accelerometer sample, one without
// throughput: one transaction in flight; the input is not ready until the result is taken
// into the output register
// reset: synchronous active-low; orientation returns to 1.0, gain and step time to defaults
module madgwick_imu_orientation_update_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // quat_w, quat_x, quat_y, quat_z
    output logic [127:0] m_tdata,
    input  logic         cfg_wen,
    input  logic         cfg_addr,
    input  logic [31:0]  cfg_wdata
);
    import mimu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_PROG, S_NA_GO, S_NA_WAIT, S_NS_GO, S_NS_WAIT,
        S_BETA, S_INTEG, S_NQ_GO, S_NQ_WAIT, S_OUT
    } state_t;

    localparam mprod_t RND29 = PW'(1) <<< 29;
    localparam mprod_t RND15 = PW'(1) <<< 15;
    localparam logic signed [AW-1:0] RND16 = AW'(1) <<< 16;

    state_t          state_reg;
    logic [PCW-1:0]  pc_reg;
    logic [1:0]      ph_reg;
    logic [1:0]      k_reg;
    logic [DW-1:0]   gain_reg;
    logic [DW-1:0]   step_reg;
    logic signed [AW-1:0] acc_reg;
    logic            acc_nz_reg;
    logic [32:0]     lo_reg;
    logic            m_tvalid_reg;
    nres_t           orient_reg [4];
    nres_t           out_reg [4];
    nres_t           g_reg [3];
    nres_t           a_reg [3];
    nres_t           an_reg [3];
    nres_t           qq_reg [4];
    nres_t           sn_reg [4];
    nvec_t           qd_reg [4];
    nvec_t           s_reg [4];
    nvec_t           qi_reg [4];

    prog_t           ent;
    mul_req_t        seq_req, nreq, mreq;
    mprod_t          prod;
    mprod_t          r30, term;
    logic signed [AW-1:0] acc_new, rnd17;
    mprod_t          bt;
    logic [NW-1:0]   mq;
    logic [NW-1:0]   dmag;
    nvec_t           qext;
    norm_ctl_t       nctl;
    norm_sts_t       nsts;
    nvec_t           nvec [4];
    nres_t           nres [4];

    function automatic mopnd_t pick(input opnd_t s);
        case (s)
            OP_Q0:   return MW'(orient_reg[0]);
            OP_Q1:   return MW'(orient_reg[1]);
            OP_Q2:   return MW'(orient_reg[2]);
            OP_Q3:   return MW'(orient_reg[3]);
            OP_GX:   return MW'(g_reg[0]);
            OP_GY:   return MW'(g_reg[1]);
            OP_GZ:   return MW'(g_reg[2]);
            OP_AX:   return MW'(an_reg[0]);
            OP_AY:   return MW'(an_reg[1]);
            OP_AZ:   return MW'(an_reg[2]);
            OP_QQ0:  return MW'(qq_reg[0]);
            OP_QQ1:  return MW'(qq_reg[1]);
            OP_QQ2:  return MW'(qq_reg[2]);
            OP_QQ3:  return MW'(qq_reg[3]);
            OP_ONE:  return MW'(Q30_ONE);
            default: return '0;
        endcase
    endfunction

    always_comb begin
        ent  = prog_entry(pc_reg);
        mq   = qd_reg[k_reg][NW-1] ? NW'(-qd_reg[k_reg]) : NW'(qd_reg[k_reg]);
        qext = NW'(orient_reg[k_reg]);
        seq_req.a = '0;
        seq_req.b = '0;
        case (state_reg)
            S_PROG: begin
                seq_req.a = pick(ent.a);
                seq_req.b = pick(ent.b);
            end
            S_BETA: begin
                seq_req.a = mopnd_t'({1'b0, gain_reg});
                seq_req.b = MW'(sn_reg[k_reg]);
            end
            S_INTEG: begin
                seq_req.a = (ph_reg == 2'd0) ? mopnd_t'({1'b0, mq[31:0]})
                                             : mopnd_t'({16'b0, mq[NW-1:32]});
                seq_req.b = mopnd_t'({1'b0, step_reg});
            end
            default: ;
        endcase
        mreq = nsts.busy ? nreq : seq_req;

        r30     = (prod + RND29) >>> 30;
        term    = ent.raw ? prod : (r30 <<< ent.shl);
        if (ent.neg) term = -term;
        acc_new = acc_reg + term[AW-1:0];
        rnd17   = (acc_new + RND16) >>> 17;
        bt      = (prod + RND15) >>> 16;
        dmag    = prod[NW-1:0] + NW'(lo_reg);

        for (int i = 0; i < 4; i++) begin
            case (state_reg)
                S_NA_GO, S_NA_WAIT: nvec[i] = (i < 3) ? NW'(a_reg[i % 3]) : '0;
                S_NS_GO, S_NS_WAIT: nvec[i] = s_reg[i];
                default:            nvec[i] = qi_reg[i];
            endcase
        end
        nctl.start = (state_reg == S_NA_GO) || (state_reg == S_NS_GO)
                  || (state_reg == S_NQ_GO);
        nctl.four  = (state_reg != S_NA_GO);
    end

    mimu_mul u_mul (
        .aclk (aclk),
        .req  (mreq),
        .prod (prod)
    );

    mimu_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (nctl),
        .vec     (nvec),
        .sts     (nsts),
        .res     (nres),
        .req     (nreq),
        .prod    (prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_tvalid_reg  <= 1'b0;
            gain_reg      <= GAIN_RST;
            step_reg      <= STEP_RST;
            orient_reg[0] <= Q30_ONE;
            orient_reg[1] <= '0;
            orient_reg[2] <= '0;
            orient_reg[3] <= '0;
        end else begin
            if (cfg_wen) begin
                case (cfg_addr)
                    REG_GAIN: gain_reg <= cfg_wdata;
                    REG_STEP: step_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) m_tvalid_reg <= 1'b0;

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        for (int i = 0; i < 3; i++) begin
                            g_reg[i] <= s_tdata[32*i +: 32];
                            a_reg[i] <= s_tdata[96 + 32*i +: 32];
                        end
                        acc_nz_reg <= (s_tdata[191:96] != '0);
                        acc_reg    <= '0;
                        pc_reg     <= '0;
                        ph_reg     <= 2'd0;
                        state_reg  <= S_PROG;
                    end
                end
                S_PROG: begin
                    if (ph_reg == 2'd0) begin
                        ph_reg <= 2'd1;
                    end else begin
                        ph_reg <= 2'd0;
                        pc_reg <= pc_reg + PCW'(1);
                        if (ent.last) begin
                            acc_reg <= '0;
                            case (ent.dst)
                                DST_QD:  qd_reg[ent.idx] <= rnd17[NW-1:0];
                                DST_QQ:  qq_reg[ent.idx] <= acc_new[QW-1:0];
                                DST_S:   s_reg[ent.idx]  <= acc_new[NW-1:0];
                                default: ;
                            endcase
                        end else begin
                            acc_reg <= acc_new;
                        end
                        k_reg <= 2'd0;
                        if (pc_reg == PC_GYRO_END) begin
                            state_reg <= acc_nz_reg ? S_NA_GO : S_INTEG;
                        end else if (pc_reg == PC_END) begin
                            state_reg <= S_NS_GO;
                        end
                    end
                end
                S_NA_GO: state_reg <= S_NA_WAIT;
                S_NA_WAIT: begin
                    if (nsts.done) begin
                        for (int i = 0; i < 3; i++) an_reg[i] <= nres[i];
                        state_reg <= S_PROG;
                    end
                end
                S_NS_GO: state_reg <= S_NS_WAIT;
                S_NS_WAIT: begin
                    if (nsts.done) begin
                        sn_reg    <= nres;
                        k_reg     <= 2'd0;
                        ph_reg    <= 2'd0;
                        state_reg <= S_BETA;
                    end
                end
                S_BETA: begin
                    if (ph_reg == 2'd0) begin
                        ph_reg <= 2'd1;
                    end else begin
                        qd_reg[k_reg] <= qd_reg[k_reg] - bt[NW-1:0];
                        ph_reg        <= 2'd0;
                        k_reg         <= k_reg + 2'd1;
                        if (k_reg == 2'd3) state_reg <= S_INTEG;
                    end
                end
                S_INTEG: begin
                    case (ph_reg)
                        2'd0: ph_reg <= 2'd1;
                        2'd1: begin
                            lo_reg <= 33'(({1'b0, prod[AW-1:0]} + 65'(32'h8000_0000)) >> 32);
                            ph_reg <= 2'd2;
                        end
                        default: begin
                            qi_reg[k_reg] <= qd_reg[k_reg][NW-1] ? qext - nvec_t'(dmag)
                                                                 : qext + nvec_t'(dmag);
                            ph_reg <= 2'd0;
                            k_reg  <= k_reg + 2'd1;
                            if (k_reg == 2'd3) state_reg <= S_NQ_GO;
                        end
                    endcase
                end
                S_NQ_GO: state_reg <= S_NQ_WAIT;
                S_NQ_WAIT: begin
                    if (nsts.done) begin
                        orient_reg <= nres;
                        state_reg  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        out_reg      <= orient_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg[3], out_reg[2], out_reg[1], out_reg[0]};

endmodule

// ===== hdl/mimu_checker.sv =====
// port-level checks of the orientation update unit and their binding
module mimu_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no result pending after reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one transaction at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready straight after a transaction");

    // a new result only appears when the unit finishes work
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while idle");

endmodule

bind madgwick_imu_orientation_update_unit mimu_checker u_mimu_checker (.*);

// ===== dv/testbench.sv =====
// self-checking testbench for the imu orientation update unit
`timescale 1ns / 100ps

module testbench;
    import mimu_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         cfg_wen;
    logic         cfg_addr;
    logic [31:0]  cfg_wdata;

    madgwick_imu_orientation_update_unit dut (.*);

    typedef struct packed {
        logic signed [31:0] az, ay, ax, gz, gy, gx;
    } imu_sample_t;

    typedef struct packed {
        logic signed [31:0] z, y, x, w;
    } quat_t;

    localparam int WATCHDOG_CYCLES = 20000;

    imu_sample_t        sample_q[$];
    quat_t              quat_expected_q[$];
    logic [63:0]        gain_model;
    logic [63:0]        dt_model;
    logic signed [63:0] att[4];
    int                 errors;
    int                 idle_cycles;
    int                 s_gap;
    int                 m_gap;
    bit                 calm;
    bit                 finished;

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    // floor((v + 2^(s-1)) / 2^s)
    function automatic logic signed [63:0] round_shr(input logic signed [63:0] v, input int s);
        logic signed [63:0] t;
        t = v + (64'sd1 <<< (s - 1));
        return t >>> s;
    endfunction

    function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        return round_shr(a * b, 30);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic unit_vector(input logic signed [63:0] c[4], input int n,
                               output logic signed [63:0] o[4]);
        logic [63:0] mg[4];
        logic [63:0] m, sum, r, u;
        m = 0;
        sum = 0;
        for (int i = 0; i < 4; i++) begin
            o[i] = 0;
            mg[i] = i < n ? mag64(c[i]) : 0;
            if (mg[i] > m) m = mg[i];
        end
        if (m == 0) return;
        while (m >= (64'd1 << 31)) begin
            for (int i = 0; i < 4; i++) mg[i] >>= 1;
            m >>= 1;
        end
        while (m < (64'd1 << 30)) begin
            for (int i = 0; i < 4; i++) mg[i] <<= 1;
            m <<= 1;
        end
        for (int i = 0; i < n; i++) sum += mg[i] * mg[i];
        r = int_sqrt(sum);
        for (int i = 0; i < n; i++) begin
            u = (mg[i] << 30) / r;
            o[i] = c[i] < 0 ? -$signed(u) : $signed(u);
        end
    endtask

    function automatic logic signed [63:0] step_integrate(input logic signed [63:0] q,
                                                          input logic signed [63:0] rate);
        logic [63:0] m, d;
        m = mag64(rate);
        d = (m >> 32) * dt_model + (((m & 64'hFFFF_FFFF) * dt_model + 64'h8000_0000) >> 32);
        return rate < 0 ? q - $signed(d) : q + $signed(d);
    endfunction

    task automatic update_attitude(input imu_sample_t smp);
        logic signed [63:0] q0, q1, q2, q3, gx, gy, gz, ax, ay, az;
        logic signed [63:0] q00, q11, q22, q33;
        logic signed [63:0] acc[4], an[4], s[4], sn[4], qd[4], qi[4], qn[4];
        quat_t res;
        q0 = att[0]; q1 = att[1]; q2 = att[2]; q3 = att[3];
        gx = smp.gx; gy = smp.gy; gz = smp.gz;
        qd[0] = round_shr(-q1 * gx - q2 * gy - q3 * gz, 17);
        qd[1] = round_shr(q0 * gx + q2 * gz - q3 * gy, 17);
        qd[2] = round_shr(q0 * gy - q1 * gz + q3 * gx, 17);
        qd[3] = round_shr(q0 * gz + q1 * gy - q2 * gx, 17);
        if (smp.ax != 0 || smp.ay != 0 || smp.az != 0) begin
            acc[0] = smp.ax; acc[1] = smp.ay; acc[2] = smp.az; acc[3] = 0;
            unit_vector(acc, 3, an);
            ax = an[0]; ay = an[1]; az = an[2];
            q00 = qmul(q0, q0); q11 = qmul(q1, q1);
            q22 = qmul(q2, q2); q33 = qmul(q3, q3);
            s[0] = 4 * qmul(q0, q22) + 2 * qmul(q2, ax) + 4 * qmul(q0, q11)
                 - 2 * qmul(q1, ay);
            s[1] = 4 * qmul(q1, q33) - 2 * qmul(q3, ax) + 4 * qmul(q00, q1)
                 - 2 * qmul(q0, ay) - 4 * q1 + 8 * qmul(q1, q11)
                 + 8 * qmul(q1, q22) + 4 * qmul(q1, az);
            s[2] = 4 * qmul(q00, q2) + 2 * qmul(q0, ax) + 4 * qmul(q2, q33)
                 - 2 * qmul(q3, ay) - 4 * q2 + 8 * qmul(q2, q11)
                 + 8 * qmul(q2, q22) + 4 * qmul(q2, az);
            s[3] = 4 * qmul(q11, q3) - 2 * qmul(q1, ax) + 4 * qmul(q22, q3)
                 - 2 * qmul(q2, ay);
            unit_vector(s, 4, sn);
            for (int i = 0; i < 4; i++) qd[i] -= round_shr($signed(gain_model) * sn[i], 16);
        end
        for (int i = 0; i < 4; i++) qi[i] = step_integrate(att[i], qd[i]);
        unit_vector(qi, 4, qn);
        for (int i = 0; i < 4; i++) att[i] = qn[i];
        res.w = qn[0][31:0]; res.x = qn[1][31:0]; res.y = qn[2][31:0]; res.z = qn[3][31:0];
        quat_expected_q = {quat_expected_q, res};
    endtask

    function automatic logic signed [31:0] rnd_field(input int kind);
        case (kind)
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 0;
            3: return $signed($urandom_range(0, 262143)) - 131072;
            4: return $signed($urandom_range(0, 2047)) - 1024;
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic imu_sample_t rnd_sample();
        imu_sample_t smp;
        int k;
        k = $urandom_range(0, 9);
        smp.gx = k < 7 ? rnd_field(3) : rnd_field($urandom_range(0, 5));
        smp.gy = k < 7 ? rnd_field(3) : rnd_field($urandom_range(0, 5));
        smp.gz = k < 7 ? rnd_field(3) : rnd_field($urandom_range(0, 5));
        smp.ax = k < 7 ? rnd_field(3) : rnd_field($urandom_range(0, 5));
        smp.ay = k < 7 ? rnd_field(3) + 32'sd655360 : rnd_field($urandom_range(0, 5));
        smp.az = k < 7 ? rnd_field(3) : rnd_field($urandom_range(0, 5));
        if ($urandom_range(0, 19) == 0) begin
            smp.ax = 0; smp.ay = 0; smp.az = 0;
        end
        return smp;
    endfunction

    // only called while the block is idle
    task automatic write_reg(input logic addr, input logic [31:0] val);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        if (addr == REG_GAIN) gain_model = val;
        else dt_model = val;
    endtask

    task automatic run_phase(input int n);
        for (int i = 0; i < n; i++) sample_q = {sample_q, rnd_sample()};
        wait (sample_q.size() == 0 && quat_expected_q.size() == 0);
        repeat (300) @(posedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                update_attitude(s_tdata);
                void'(sample_q.pop_front());
                idle_cycles = 0;
            end
            if (s_tvalid && !s_tready) begin
            end else if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                s_gap = $urandom_range(0, 5);
                s_tvalid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= sample_q[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge aclk) begin
        quat_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                idle_cycles = 0;
                if (quat_expected_q.size() == 0) begin
                    $display("%0t unexpected quaternion %h", $time, got);
                    errors++;
                end else begin
                    want = quat_expected_q.pop_front();
                    if (got.w !== want.w) begin
                        $display("%0t quat_w exp %h got %h", $time, want.w, got.w); errors++;
                    end
                    if (got.x !== want.x) begin
                        $display("%0t quat_x exp %h got %h", $time, want.x, got.x); errors++;
                    end
                    if (got.y !== want.y) begin
                        $display("%0t quat_y exp %h got %h", $time, want.y, got.y); errors++;
                    end
                    if (got.z !== want.z) begin
                        $display("%0t quat_z exp %h got %h", $time, want.z, got.z); errors++;
                    end
                end
            end
            if (m_gap > 0) begin
                m_gap--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_gap = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn && !finished) begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("madgwick_imu_orientation_update_unit test failed");
                $finish;
            end
        end
    end

    initial begin
        imu_sample_t smp;
        errors = 0;
        idle_cycles = 0;
        calm = 1'b0;
        finished = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_wen = 1'b0;
        cfg_addr = REG_GAIN;
        cfg_wdata = '0;
        gain_model = GAIN_RST;
        dt_model = STEP_RST;
        att[0] = 64'sd1 <<< 30; att[1] = 0; att[2] = 0; att[3] = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: defaults, field extremes, zero accelerometer
        smp = '0; sample_q = {sample_q, smp};
        smp.ay = 32'sh0001_0000; sample_q = {sample_q, smp};
        smp = {6{32'sh7FFF_FFFF}}; sample_q = {sample_q, smp};
        smp = {6{32'sh8000_0000}}; sample_q = {sample_q, smp};
        smp = '0; smp.gx = 32'sh7FFF_FFFF; smp.gy = 32'sh8000_0000; sample_q = {sample_q, smp};
        smp = '0; smp.gz = 32'sh0003_0000; sample_q = {sample_q, smp};
        smp = '0; smp.ax = 1; sample_q = {sample_q, smp};
        smp = '0; smp.az = 32'sh8000_0000; smp.ax = 32'sh7FFF_FFFF; sample_q = {sample_q, smp};
        smp = {32'sh0000_0001, 32'shFFFF_FFFF, 32'sh5555_5555,
               32'shAAAA_AAAA, 32'sh0000_0000, 32'sh1234_5678};
        sample_q = {sample_q, smp};
        run_phase(0);

        // register settings: extremes first, then moderate, random and default values
        write_reg(REG_GAIN, 32'hFFFF_FFFF);
        write_reg(REG_STEP, 32'hFFFF_FFFF);
        run_phase(60);
        write_reg(REG_GAIN, 32'h0000_0000);
        write_reg(REG_STEP, 32'h0000_0000);
        run_phase(60);
        write_reg(REG_GAIN, 32'h0001_0000);
        write_reg(REG_STEP, 32'h0100_0000);
        run_phase(300);
        write_reg(REG_GAIN, $urandom);
        write_reg(REG_STEP, $urandom);
        run_phase(300);
        write_reg(REG_GAIN, GAIN_RST);
        write_reg(REG_STEP, STEP_RST);
        run_phase(900);
        calm = 1'b1;
        run_phase(380);

        finished = 1'b1;
        if (errors == 0 && quat_expected_q.size() == 0) begin
            $display("madgwick_imu_orientation_update_unit test passed");
        end else begin
            $display("madgwick_imu_orientation_update_unit test failed");
        end
        $finish;
    end

endmodule
